// ===== design/ladder_lowpass_filter_4pole_core_defines.svh =====
// ----------------------------------------------------------------------------
// Ladder lowpass core: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge, reset masked.
// ----------------------------------------------------------------------------
`ifndef LADDER_LOWPASS_FILTER_4POLE_CORE_DEFINES_SVH
`define LADDER_LOWPASS_FILTER_4POLE_CORE_DEFINES_SVH

// Same-cycle implication
`define LLF4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LLF4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/llf4_pkg.sv =====
// ----------------------------------------------------------------------------
// Ladder lowpass package
// Constants, controller/datapath command types and the b0 coefficient table.
// ----------------------------------------------------------------------------
package llf4_pkg;

  localparam int unsigned TAN_TABLE_BITS = 8;
  localparam int unsigned TABLE_SIZE     = (1 << TAN_TABLE_BITS) + 1;
  localparam int unsigned RATIO_FRAC     = 24;
  localparam int unsigned RATIO_SHIFT    = RATIO_FRAC - TAN_TABLE_BITS;
  localparam int unsigned RATIO_W        = 23;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 23'd8220835;
  localparam int unsigned COEF_FRAC      = 23;
  localparam int unsigned COEF_W         = 24;
  localparam int unsigned STAGES         = 4;
  localparam int unsigned STAGE_IDX_W    = 2;
  localparam int unsigned CUTOFF_W       = 16;
  localparam int unsigned RES_W          = 14;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned FS_W           = 18;
  localparam int unsigned DIVIDEND_W     = CUTOFF_W + RATIO_FRAC;
  localparam int unsigned DIV_CNT_W      = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = FS_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd1;
  localparam logic [FS_W-1:0] FS_RESET = 18'd48000;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_STEP,
    OP_RATIO,
    OP_RD0,
    OP_RD1,
    OP_MUL_INT,
    OP_B0,
    OP_MUL_FB,
    OP_X,
    OP_MUL_B,
    OP_MUL_A,
    OP_Y,
    OP_OUT,
    OP_PASS
  } dp_op_e;

  typedef struct packed {
    dp_op_e                 op;
    logic [STAGE_IDX_W-1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
  } dp_status_t;

  typedef logic [COEF_W-1:0] coef_tbl_t [TABLE_SIZE];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // Shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = num;
    for (int k = 0; k < 64; k++) begin
      r = {r[63:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // n*(n+1) divisor of Taylor term j
  function automatic logic [63:0] taylor_div(int j, bit is_sin);
    logic [63:0] n;
    n = 64'(is_sin ? 2 : 1) + 64'(2 * j);
    return n * (n + 64'd1);
  endfunction

  // b0 = s/(s+c) over ratio 0..0.5, Q1.23
  function automatic coef_tbl_t build_coef_table();
    coef_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] den;
    logic signed [63:0] b;
    for (int i = 0; i < int'(TABLE_SIZE); i++) begin
      x  = (HALF_PI_Q30 * 64'(i)) >> TAN_TABLE_BITS;
      x2 = (x * x) >> 30;
      term = x;
      s    = $signed(x);
      for (int j = 0; j < 8; j++) begin
        term = udiv64((term * x2) >> 30, taylor_div(j, 1'b1));
        if (j % 2 == 1) s = s + $signed(term);
        else            s = s - $signed(term);
      end
      term = ONE_Q30;
      c    = $signed(ONE_Q30);
      for (int j = 0; j < 8; j++) begin
        term = udiv64((term * x2) >> 30, taylor_div(j, 1'b0));
        if (j % 2 == 1) c = c + $signed(term);
        else            c = c - $signed(term);
      end
      if (s < 0) s = 0;
      if (c < 0) c = 0;
      den = s + c;
      if (den <= 0) begin
        b = 64'sd1 <<< COEF_FRAC;
      end else begin
        b = $signed(udiv64(64'((s <<< COEF_FRAC) + (den >>> 1)), 64'(den)));
        if (b > (64'sd1 <<< COEF_FRAC)) b = 64'sd1 <<< COEF_FRAC;
      end
      tbl[i] = b[COEF_W-1:0];
    end
    return tbl;
  endfunction

  localparam coef_tbl_t COEF_TABLE = build_coef_table();

endpackage

// ===== design/llf4_datapath.sv =====
// ----------------------------------------------------------------------------
// Ladder lowpass datapath
// Config registers, cutoff divider, table interpolation, shared multiplier,
// stage state and output register, driven one micro-op per cycle.
// ----------------------------------------------------------------------------
module llf4_datapath #(
  parameter int unsigned STATE_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [llf4_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [llf4_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [llf4_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic [llf4_pkg::CUTOFF_W-1:0]       cutoff_hz_i,
  input  logic [llf4_pkg::RES_W-1:0]          resonance_i,
  input  llf4_pkg::dp_cmd_t                   cmd_i,
  output llf4_pkg::dp_status_t                status_o,
  output logic signed [llf4_pkg::SAMPLE_W-1:0] out_sample_o
);
  import llf4_pkg::*;

  localparam int unsigned W  = STATE_WIDTH;
  localparam int unsigned AW = 26;
  localparam int unsigned BW = W + 2;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned OSH = W - SAMPLE_W;
  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
  localparam logic signed [PW-1:0] O_HI = PW'(32767);
  localparam logic signed [PW-1:0] O_LO = -PW'(32768);

  function automatic logic signed [W-1:0] sat_state(logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[W-1:0];
  endfunction

  // Config registers
  logic            enabled_q;
  logic [FS_W-1:0] fs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      fs_q      <= FS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: enabled_q <= cfg_data_i[0];
        CFG_RATE:   fs_q      <= cfg_data_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  assign status_o.enabled = enabled_q;

  // Working registers
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic [RES_W-1:0]            k_q;
  logic [DIVIDEND_W-1:0]       quo_q;
  logic [FS_W:0]               rem_q;
  logic [TAN_TABLE_BITS-1:0]   idx_q;
  logic [RATIO_SHIFT-1:0]      frac_q;
  logic [COEF_W-1:0]           t0_q;
  logic [COEF_W-1:0]           t1_q;
  logic signed [PW-1:0]        prod_q;
  logic signed [PW-1:0]        acc_q;
  logic signed [COEF_W:0]      b0_q;
  logic signed [COEF_W:0]      a1_q;
  logic signed [W-1:0]         x_q;
  logic signed [W-1:0]         pin_q  [STAGES];
  logic signed [W-1:0]         pout_q [STAGES];
  logic signed [SAMPLE_W-1:0]  out_q;

  // Restoring divide step
  logic [FS_W:0] div_t;
  logic          div_ge;
  logic [FS_W:0] div_rem;
  always_comb begin
    div_t   = {rem_q[FS_W-1:0], quo_q[DIVIDEND_W-1]};
    div_ge  = div_t >= {1'b0, fs_q};
    div_rem = div_ge ? div_t - {1'b0, fs_q} : div_t;
  end

  // Ratio clamp and table split (index never reaches the last entry)
  logic [RATIO_W-1:0] ratio_c;
  logic [RATIO_W:0]   u_c;
  always_comb begin
    if (fs_q == '0 || quo_q > DIVIDEND_W'(RATIO_MAX)) ratio_c = RATIO_MAX;
    else                                                ratio_c = quo_q[RATIO_W-1:0];
    u_c = {ratio_c, 1'b0};
  end

  // Coefficient table read, one address per cycle
  logic [TAN_TABLE_BITS:0] tbl_addr;
  logic [COEF_W-1:0]       tbl_rd;
  always_comb begin
    tbl_addr = (cmd_i.op == OP_RD1) ? {1'b0, idx_q} + 1'b1 : {1'b0, idx_q};
    tbl_rd   = COEF_TABLE[tbl_addr];
  end

  // Shared multiplier operand select
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_c;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_INT: begin
        mul_a = $signed({2'b00, t1_q}) - $signed({2'b00, t0_q});
        mul_b = $signed({{(BW - RATIO_SHIFT){1'b0}}, frac_q});
      end
      OP_MUL_FB: begin
        mul_a = $signed({{(AW - RES_W){1'b0}}, k_q});
        mul_b = BW'(pout_q[STAGES-1]);
      end
      OP_MUL_B: begin
        mul_a = AW'(b0_q);
        mul_b = BW'(x_q) + BW'(pin_q[cmd_i.stage]);
      end
      OP_MUL_A: begin
        mul_a = AW'(a1_q);
        mul_b = BW'(pout_q[cmd_i.stage]);
      end
      default: ;
    endcase
    prod_c = PW'(mul_a) * PW'(mul_b);
  end

  // Post-multiply arithmetic
  logic signed [PW-1:0]     b0_w;
  logic signed [COEF_W:0]   b0_c;
  logic signed [COEF_W+1:0] a1_w;
  logic signed [PW-1:0]     fb_w;
  logic signed [PW-1:0]     xs_w;
  logic signed [PW-1:0]     y_w;
  logic signed [PW-1:0]     o_w;
  logic signed [PW-1:0]     o_s;
  always_comb begin
    b0_w = PW'($signed({1'b0, t0_q})) + (prod_q >>> RATIO_SHIFT);
    b0_c = b0_w[COEF_W:0];
    a1_w = $signed({b0_c, 1'b0}) - (26'sd1 <<< COEF_FRAC);
    fb_w = (prod_q + (PW'(1) <<< 11)) >>> 12;
    xs_w = (PW'(sample_q) <<< OSH) - fb_w;
    y_w  = (acc_q - prod_q + (PW'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    o_w  = (PW'(x_q) + (PW'(1) <<< (OSH - 1))) >>> OSH;
    o_s  = o_w;
    if (o_w > O_HI) o_s = O_HI;
    if (o_w < O_LO) o_s = O_LO;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sample_q <= in_sample_i;
        k_q      <= resonance_i;
        quo_q    <= {cutoff_hz_i, {RATIO_FRAC{1'b0}}};
        rem_q    <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= div_rem;
        quo_q <= {quo_q[DIVIDEND_W-2:0], div_ge};
      end
      OP_RATIO: begin
        idx_q  <= u_c[RATIO_W:RATIO_SHIFT];
        frac_q <= u_c[RATIO_SHIFT-1:0];
      end
      OP_RD0:     t0_q   <= tbl_rd;
      OP_RD1:     t1_q   <= tbl_rd;
      OP_MUL_INT: prod_q <= prod_c;
      OP_B0: begin
        b0_q <= b0_c;
        a1_q <= a1_w[COEF_W:0];
      end
      OP_MUL_FB:  prod_q <= prod_c;
      OP_X:       x_q    <= sat_state(xs_w);
      OP_MUL_B:   prod_q <= prod_c;
      OP_MUL_A: begin
        acc_q  <= prod_q;
        prod_q <= prod_c;
      end
      OP_Y:       x_q    <= sat_state(y_w);
      OP_OUT:     out_q  <= o_s[SAMPLE_W-1:0];
      OP_PASS:    out_q  <= sample_q;
      default: ;
    endcase
  end

  // Stage state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(STAGES); i++) begin
        pin_q[i]  <= '0;
        pout_q[i] <= '0;
      end
    end else if (cmd_i.op == OP_Y) begin
      pin_q[cmd_i.stage]  <= x_q;
      pout_q[cmd_i.stage] <= sat_state(y_w);
    end
  end

  assign out_sample_o = out_q;

endmodule

// ===== design/llf4_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ladder lowpass controller
// Sequences the datapath micro-ops per sample and owns both handshakes.
// ----------------------------------------------------------------------------
`include "ladder_lowpass_filter_4pole_core_defines.svh"

module llf4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  llf4_pkg::dp_status_t status_i,
  output llf4_pkg::dp_cmd_t    cmd_o
);
  import llf4_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIV   = 4'd1;
  localparam logic [3:0] S_RATIO = 4'd2;
  localparam logic [3:0] S_TAB0  = 4'd3;
  localparam logic [3:0] S_TAB1  = 4'd4;
  localparam logic [3:0] S_MINT  = 4'd5;
  localparam logic [3:0] S_B0    = 4'd6;
  localparam logic [3:0] S_MFB   = 4'd7;
  localparam logic [3:0] S_X     = 4'd8;
  localparam logic [3:0] S_MB    = 4'd9;
  localparam logic [3:0] S_MA    = 4'd10;
  localparam logic [3:0] S_Y     = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_PASS  = 4'd13;

  logic [3:0]             state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [STAGE_IDX_W-1:0] stage_q, stage_d;
  logic                   out_valid_q, out_valid_d;
  logic                   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stage_d     = stage_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    cmd_o.stage = stage_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = '0;
          state_d  = status_i.enabled ? S_DIV : S_PASS;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = S_RATIO;
      end
      S_RATIO: begin
        cmd_o.op = OP_RATIO;
        state_d  = S_TAB0;
      end
      S_TAB0: begin
        cmd_o.op = OP_RD0;
        state_d  = S_TAB1;
      end
      S_TAB1: begin
        cmd_o.op = OP_RD1;
        state_d  = S_MINT;
      end
      S_MINT: begin
        cmd_o.op = OP_MUL_INT;
        state_d  = S_B0;
      end
      S_B0: begin
        cmd_o.op = OP_B0;
        state_d  = S_MFB;
      end
      S_MFB: begin
        cmd_o.op = OP_MUL_FB;
        state_d  = S_X;
      end
      S_X: begin
        cmd_o.op = OP_X;
        stage_d  = '0;
        state_d  = S_MB;
      end
      S_MB: begin
        cmd_o.op = OP_MUL_B;
        state_d  = S_MA;
      end
      S_MA: begin
        cmd_o.op = OP_MUL_A;
        state_d  = S_Y;
      end
      S_Y: begin
        cmd_o.op = OP_Y;
        if (stage_q == STAGE_IDX_W'(STAGES - 1)) begin
          state_d = S_OUT;
        end else begin
          stage_d = stage_q + 1'b1;
          state_d = S_MB;
        end
      end
      S_OUT, S_PASS: begin
        if (slot_free) begin
          cmd_o.op    = (state_q == S_OUT) ? OP_OUT : OP_PASS;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  // Checks
  `LLF4_ASSERT_IMPL(a_out_slot_free, clk_i, rst_ni,
    (cmd_o.op == OP_OUT || cmd_o.op == OP_PASS), slot_free, "result written over pending beat")
  `LLF4_ASSERT_NEXT(a_last_stage_out, clk_i, rst_ni,
    (state_q == S_Y && stage_q == STAGE_IDX_W'(STAGES - 1)), (state_q == S_OUT),
    "cascade did not finish after last stage")
  `LLF4_ASSERT_IMPL(a_div_bound, clk_i, rst_ni,
    (state_q == S_DIV), (cnt_q <= DIV_LAST), "divider ran past its step count")
  `LLF4_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni,
    (in_valid_i && !in_stall_o), (state_q == S_DIV || state_q == S_PASS),
    "accepted beat not started")

endmodule

// ===== design/ladder_lowpass_filter_4pole_core.sv =====
// ----------------------------------------------------------------------------
// Four-pole ladder lowpass core
// Four cascaded bilinear one-pole lowpass stages with resonance feedback.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | in_sample_i, cutoff_hz_i, resonance_i
//  out     | output    | out_valid_o / out_stall_i  | out_sample_o
//  cfg     | input     | cfg_we_i (no wait)         | cfg_index_i, cfg_data_i
//
// A filtered beat's result is valid after bit-serial cutoff/rate division,
// then table read, interpolation, feedback and four stages on the shared
// multiplier (ten products). A bypassed beat's result loads from the pass
// state once the output slot is free. One beat is in flight; the next is
// accepted the cycle after the result register loads, even while that result
// is stalled. A stalled result holds off loading the following one.
// Reset clears stage state and loads the register defaults; no clear pass.
module ladder_lowpass_filter_4pole_core #(
  parameter int unsigned STATE_WIDTH = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [llf4_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic [llf4_pkg::CUTOFF_W-1:0]        cutoff_hz_i,
  input  logic [llf4_pkg::RES_W-1:0]           resonance_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [llf4_pkg::SAMPLE_W-1:0] out_sample_o,
  input  logic                                 cfg_we_i,
  input  logic [llf4_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [llf4_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import llf4_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  llf4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  llf4_datapath #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (in_sample_i),
    .cutoff_hz_i  (cutoff_hz_i),
    .resonance_i  (resonance_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_sample_o (out_sample_o)
  );

endmodule

// ===== tb/sv/ladder_lowpass_filter_4pole_core_test.sv =====
// ----------------------------------------------------------------------------
// Ladder lowpass core testbench
// Drives sample beats with random idling on both sides, predicts the filter
// output in fixed point and checks every result beat in order.
// ----------------------------------------------------------------------------
module ladder_lowpass_filter_4pole_core_test;
  import llf4_pkg::*;

  localparam int SW = 24;

  // Scoreboard: fixed-point filter predictor plus queue of expected samples
  class ladder_scoreboard;
    logic signed [63:0] b0_tbl [TABLE_SIZE];
    logic signed [63:0] prev_in [STAGES];
    logic signed [63:0] prev_out [STAGES];
    bit                 enabled;
    logic [FS_W-1:0]    rate;
    logic [15:0]        expected_q[$];
    int                 mismatches;
    int                 checked;

    function new();
      logic [63:0] x, x2, term;
      logic signed [63:0] s, c, den, b;
      logic [63:0] n;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        x  = (64'd1686629713 * 64'(i)) >> TAN_TABLE_BITS;
        x2 = (x * x) >> 30;
        term = x; s = x; n = 2;
        for (int j = 0; j < 8; j++) begin
          term = ((term * x2) >> 30) / (n * (n + 1));
          if (j & 1) s = s + $signed(term); else s = s - $signed(term);
          n += 2;
        end
        term = 64'd1073741824; c = 64'sd1073741824; n = 1;
        for (int j = 0; j < 8; j++) begin
          term = ((term * x2) >> 30) / (n * (n + 1));
          if (j & 1) c = c + $signed(term); else c = c - $signed(term);
          n += 2;
        end
        if (s < 0) s = 0;
        if (c < 0) c = 0;
        den = s + c;
        if (den <= 0) b = 64'sd1 <<< 23;
        else begin
          b = ((s <<< 23) + den / 2) / den;
          if (b > (64'sd1 <<< 23)) b = 64'sd1 <<< 23;
        end
        b0_tbl[i] = b;
      end
      reset_state();
      mismatches = 0;
      checked = 0;
    endfunction

    function void reset_state();
      enabled = 1'b1;
      rate = FS_RESET;
      foreach (prev_in[i]) begin
        prev_in[i] = 0;
        prev_out[i] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_ENABLE) enabled = val[0];
      else if (idx == CFG_RATE) rate = val;
    endfunction

    // floor shift with half-up rounding
    function logic signed [63:0] round_shift(logic signed [63:0] v, int sh);
      return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function logic signed [63:0] clip(logic signed [63:0] v, int bits);
      logic signed [63:0] hi, lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : (v < lo) ? lo : v;
    endfunction

    function logic signed [63:0] coef_b0(logic [15:0] cutoff);
      logic [63:0] ratio, u, idx, frac;
      if (rate == 0) ratio = 64'd8220835;
      else ratio = (64'(cutoff) << 24) / 64'(rate);
      if (ratio > 64'd8220835) ratio = 64'd8220835;
      u = ratio * 2;
      idx = u >> RATIO_SHIFT;
      frac = u & ((64'd1 << RATIO_SHIFT) - 1);
      if (idx >= TABLE_SIZE - 1) begin
        idx = TABLE_SIZE - 2;
        frac = (64'd1 << RATIO_SHIFT) - 1;
      end
      return b0_tbl[idx] +
        $signed((64'(b0_tbl[idx + 1] - b0_tbl[idx]) * frac) >> RATIO_SHIFT);
    endfunction

    // Note an accepted input beat
    function void note_input(logic signed [15:0] smp, logic [15:0] cutoff,
                             logic [13:0] k);
      logic signed [63:0] b0, a1, x, y;
      if (!enabled) begin
        expected_q.push_back(smp);
        return;
      end
      b0 = coef_b0(cutoff);
      a1 = 2 * b0 - (64'sd1 <<< 23);
      x = 64'(smp) <<< (SW - 16);
      x = clip(x - round_shift($signed({50'd0, k}) * prev_out[STAGES-1], 12), SW);
      for (int s = 0; s < STAGES; s++) begin
        y = clip(round_shift(b0 * (x + prev_in[s]) - a1 * prev_out[s], 23), SW);
        prev_in[s] = x;
        prev_out[s] = y;
        x = y;
      end
      expected_q.push_back(16'(clip(round_shift(x, SW - 16), 16)));
    endfunction

    // Check one result beat
    function void check_result(logic [15:0] got);
      logic [15:0] want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d", $signed(got));
        return;
      end
      want = expected_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out_sample mismatch: expected %0d got %0d",
                   $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SAMPLE_W-1:0] in_sample_i = '0;
  logic [CUTOFF_W-1:0] cutoff_hz_i = '0;
  logic [RES_W-1:0] resonance_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ladder_scoreboard sb;
  bit quiet;       // no idling in the last part
  bit stim_done;
  int sent;

  always #1 clk_i = ~clk_i;

  ladder_lowpass_filter_4pole_core u_dut (.*);

  // Write one register while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Send one sample beat, with an optional idle burst before it
  task automatic send_beat(logic [15:0] smp, logic [15:0] cutoff, logic [13:0] k);
    if (!quiet && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_sample_i <= smp;
    cutoff_hz_i <= cutoff;
    resonance_i <= k;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(smp, cutoff, k);
    in_valid_i <= 1'b0;
    sent++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random content; mostly musical cutoffs, some full-range
  task automatic send_random(int n);
    logic [15:0] cut;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: cut = $urandom_range(0, 65535);
        1: cut = $urandom_range(20, 2000);
        default: cut = $urandom_range(0, 24000);
      endcase
      send_beat($urandom_range(0, 65535), cut, $urandom_range(0, 16383));
    end
  endtask

  // Result side: random stall bursts, check on accept
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_sample_o);
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int rates[6] = '{8000, 192000, 44100, 96000, 0, 262143};
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, clamping, bypass
    send_beat(16'h7FFF, 16'd0, 14'd0);
    send_beat(16'h8000, 16'd65535, 14'h3FFF);
    send_beat(16'h7FFF, 16'd23520, 14'h3FFF);
    send_beat(16'h8000, 16'd23519, 14'd0);
    send_beat(16'h7FFF, 16'd1000, 14'h3FFF);
    send_beat(16'h8000, 16'd1000, 14'h3FFF);
    send_beat(16'h0000, 16'd12000, 14'd4096);
    send_beat(16'h5555, 16'hAAAA, 14'h2AAA);
    send_beat(16'hAAAA, 16'h5555, 14'h1555);
    drain();
    write_reg(CFG_ENABLE, 18'h3FFFE);   // upper bits ignored: disabled
    send_beat(16'h8000, 16'd500, 14'd100);
    send_beat(16'h7FFF, 16'd500, 14'd100);
    drain();
    write_reg(2'd3, 18'h3FFFF);         // unused index
    write_reg(CFG_ENABLE, 18'd1);
    send_beat(16'h1234, 16'd500, 14'd100);
    drain();

    // Random phases across rates and enable settings
    foreach (rates[r]) begin
      write_reg(CFG_RATE, CFG_DATA_W'(rates[r]));
      write_reg(CFG_ENABLE, (r == 3) ? 18'd0 : 18'd1);
      send_random(290);
      drain();
    end
    write_reg(CFG_RATE, 18'd48000);
    write_reg(CFG_ENABLE, 18'd1);
    quiet = 1'b1;
    send_random(180);
    drain();
    repeat (70) @(posedge clk_i);

    $display("covered %0d sample beats over six rate settings, bypass and clamped cutoffs",
             sent);
    $display("checked %0d result beats, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/llf4_pkg.sv
design/llf4_datapath.sv
design/llf4_ctrl.sv
design/ladder_lowpass_filter_4pole_core.sv
tb/sv/ladder_lowpass_filter_4pole_core_test.sv
